[src/sab_pkg.sv]
// Shared types and constants for the stage schedule ahead/behind tracker.
package sab_pkg;

    // Default table depth.
    localparam int MAX_SEGMENTS_DEF = 64;

    // Field widths.
    localparam int LEN_W   = 32;
    localparam int SPD_W   = 40;
    localparam int TIME_W  = 40;
    localparam int ACT_W   = 40;
    localparam int CUR_W   = 7;
    localparam int IDX_W   = 6;
    localparam int SIU_W   = 7;
    localparam int AHEAD_W = 48;
    localparam int STAT_W  = 3;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 56;

    // Arithmetic widths.
    localparam int NUM_W  = 64;
    localparam int LENC_W = 38;
    localparam int D_W    = 42;
    localparam int TC_W   = 62;

    localparam logic [21:0] MS_PER_HOUR = 22'd3600000;
    localparam logic [NUM_W-1:0] CLAMP61 = 64'h2000_0000_0000_0000;
    localparam logic signed [63:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] OUT_MIN = -64'sh0000_8000_0000_0000;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_NO_SEG    = 3'd1,
        STAT_NO_ELAPSE = 3'd2,
        STAT_HOLE      = 3'd3,
        STAT_NO_SPEED  = 3'd4,
        STAT_BEYOND    = 3'd5
    } t_status;

    // Item kinds.
    typedef enum logic {
        MODE_LOAD  = 1'b0,
        MODE_QUERY = 1'b1
    } t_mode;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CHECK,
        ST_READ,
        ST_LATCH,
        ST_EVAL,
        ST_NEXT,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_ACC,
        ST_POST,
        ST_FIN,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    load_wr;
        logic    rd;
        logic    latch;
        logic    mul_lo;
        logic    mul_hi;
        logic    div_go;
        logic    acc;
        logic    post;
        logic    fin;
        logic    idx_inc;
        logic    final_sel;
        logic    set_status;
        t_status status;
        logic    out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mode;
        logic cur_neg;
        logic n_zero;
        logic elapsed_pos;
        logic spd_zero;
        logic len_zero;
        logic idx_lt_cur;
        logic is_last;
        logic cur_ge_n;
        logic vcur_zero;
        logic div_done;
        logic out_free;
    } t_flags;

endpackage

[src/sab_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module sab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/sab_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
module sab_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [sab_pkg::NUM_W-1:0]       i_num,
    input  logic [sab_pkg::SPD_W-1:0]       i_den,
    output logic                            o_done,
    output logic [sab_pkg::NUM_W-1:0]       o_quo
);

    localparam int CW = $clog2(sab_pkg::NUM_W + 1);

    logic [sab_pkg::NUM_W-1:0] r_q;
    logic [sab_pkg::SPD_W-1:0] r_rem;
    logic [CW-1:0]             r_cnt;
    logic                      r_busy;
    logic [sab_pkg::SPD_W:0]   rem_sh;
    logic [sab_pkg::SPD_W+1:0] diff;
    logic                      ge;

    // Shift in the next numerator bit and trial-subtract the divisor.
    assign rem_sh = {r_rem, r_q[sab_pkg::NUM_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, i_den};
    assign ge     = !diff[sab_pkg::SPD_W+1];

    // Control of the iteration count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(sab_pkg::NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Quotient and partial remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[sab_pkg::NUM_W-2:0], ge};
            r_rem <= ge ? diff[sab_pkg::SPD_W-1:0] : rem_sh[sab_pkg::SPD_W-1:0];
        end
    end

    assign o_done = !r_busy && !i_start;
    assign o_quo  = r_q;

endmodule

[src/sab_datapath.sv]
// Datapath: segment table, sums, scaled time arithmetic and result register.
module sab_datapath #(
    parameter int MAX_SEGMENTS = sab_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sab_pkg::t_cmd                     i_cmd,
    output sab_pkg::t_flags                   o_flags,
    input  logic [sab_pkg::IN_DATA_W-1:0]     i_in_data,
    input  logic                              i_in_user,
    input  logic [sab_pkg::TIME_W-1:0]        i_stage_start,
    input  logic [sab_pkg::SIU_W-1:0]         i_siu,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [sab_pkg::OUT_DATA_W-1:0]    o_out_data
);

    localparam int AW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int ENT_W = sab_pkg::LEN_W + sab_pkg::SPD_W;
    localparam int DM_W  = sab_pkg::D_W - 1;

    // Latched item fields.
    logic [sab_pkg::IDX_W-1:0]        r_index;
    logic [sab_pkg::LEN_W-1:0]        r_elen;
    logic [sab_pkg::SPD_W-1:0]        r_espd;
    logic [sab_pkg::CUR_W-1:0]        r_cur;
    logic [sab_pkg::TIME_W-1:0]       r_now;
    logic [sab_pkg::ACT_W-1:0]        r_act;

    // Walk state.
    logic [sab_pkg::SIU_W-1:0]        r_idx;
    logic [sab_pkg::LEN_W-1:0]        r_len;
    logic [sab_pkg::SPD_W-1:0]        r_spd;
    logic [sab_pkg::SPD_W-1:0]        r_vcur;
    logic [sab_pkg::LENC_W-1:0]       r_lenc;
    logic [sab_pkg::TC_W-1:0]         r_tc;
    logic                             r_dneg;
    logic [DM_W-1:0]                  r_dmag;
    logic [46:0]                      r_plo;
    logic [sab_pkg::NUM_W-1:0]        r_num;

    // Result registers.
    logic signed [sab_pkg::AHEAD_W-1:0] r_res;
    sab_pkg::t_status                   r_status;
    logic                               r_out_valid;
    logic signed [sab_pkg::AHEAD_W-1:0] r_out_ahead;
    sab_pkg::t_status                   r_out_status;

    logic [sab_pkg::SIU_W-1:0]        n_seg;
    logic [sab_pkg::SIU_W-1:0]        cur_u;
    logic [sab_pkg::SIU_W-1:0]        last;
    logic signed [sab_pkg::TIME_W:0]  elapsed;
    logic                             ram_we;
    logic [ENT_W-1:0]                 ram_rdata;
    logic [47:0]                      mul_op;
    logic [sab_pkg::SPD_W-1:0]        den;
    logic                             div_done;
    logic [sab_pkg::NUM_W-1:0]        quo;
    logic [sab_pkg::TC_W-1:0]         qcl;
    logic [sab_pkg::TC_W:0]           tc_sum;
    logic signed [sab_pkg::D_W-1:0]   d_val;
    logic signed [63:0]               term;

    // Stage size limited to the table, current segment and last walked index.
    assign n_seg = (32'(i_siu) > MAX_SEGMENTS) ? sab_pkg::SIU_W'(MAX_SEGMENTS) : i_siu;
    assign cur_u = {1'b0, r_cur[sab_pkg::CUR_W-2:0]};
    assign last  = (cur_u < n_seg) ? cur_u : (n_seg - 1'b1);
    assign elapsed = $signed({1'b0, r_now}) - $signed({1'b0, i_stage_start});

    // Segment table: length in the low bits, speed above.
    assign ram_we = i_cmd.load_wr && (32'(r_index) < MAX_SEGMENTS);

    sab_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(r_index)),
        .i_wdata ({r_espd, r_elen}),
        .i_raddr (AW'(r_idx)),
        .o_rdata (ram_rdata)
    );

    // Operand and divisor for either a completed segment or the current one.
    assign mul_op = i_cmd.final_sel ? {7'b0, r_dmag} : {16'b0, r_len};
    assign den    = i_cmd.final_sel ? r_vcur : r_spd;

    sab_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_go),
        .i_num   (r_num),
        .i_den   (den),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    // Clamp of a scaled time and the running ideal-time sum.
    assign qcl    = (quo > sab_pkg::CLAMP61) ? sab_pkg::TC_W'(sab_pkg::CLAMP61)
                                             : quo[sab_pkg::TC_W-1:0];
    assign tc_sum = {1'b0, r_tc} + {1'b0, qcl};
    assign d_val  = sab_pkg::D_W'($signed(r_act)) - $signed({4'b0, r_lenc});
    assign term   = (r_dneg ? -$signed({2'b0, qcl}) : $signed({2'b0, qcl}))
                  - 64'(elapsed) + $signed({2'b0, r_tc});

    // Item capture and walk registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_index <= i_in_data[5:0];
            r_elen  <= i_in_data[37:6];
            r_espd  <= i_in_data[77:38];
            r_cur   <= i_in_data[84:78];
            r_now   <= i_in_data[124:85];
            r_act   <= i_in_data[164:125];
            r_idx   <= '0;
            r_lenc  <= '0;
            r_tc    <= '0;
        end
        if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.latch) begin
            r_len <= ram_rdata[sab_pkg::LEN_W-1:0];
            r_spd <= ram_rdata[ENT_W-1:sab_pkg::LEN_W];
            if (r_idx == cur_u) begin
                r_vcur <= ram_rdata[ENT_W-1:sab_pkg::LEN_W];
            end
        end
        if (i_cmd.mul_lo) begin
            r_plo <= 47'(mul_op[23:0]) * 47'(sab_pkg::MS_PER_HOUR) + 47'(den >> 1);
        end
        if (i_cmd.mul_hi) begin
            r_num <= {40'(mul_op[47:24]) * 40'(sab_pkg::MS_PER_HOUR), 24'b0}
                   + sab_pkg::NUM_W'(r_plo);
        end
        if (i_cmd.acc) begin
            r_lenc <= r_lenc + sab_pkg::LENC_W'(r_len);
            r_tc   <= tc_sum[sab_pkg::TC_W] ? sab_pkg::TC_W'(sab_pkg::CLAMP61)
                    : ((tc_sum[sab_pkg::TC_W-1:0] > sab_pkg::TC_W'(sab_pkg::CLAMP61))
                       ? sab_pkg::TC_W'(sab_pkg::CLAMP61) : tc_sum[sab_pkg::TC_W-1:0]);
        end
        if (i_cmd.post) begin
            r_dneg <= d_val[sab_pkg::D_W-1];
            r_dmag <= d_val[sab_pkg::D_W-1] ? DM_W'(-d_val) : d_val[sab_pkg::D_W-2:0];
        end
    end

    // Result value and status.
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_status) begin
            r_res    <= '0;
            r_status <= i_cmd.status;
        end else if (i_cmd.fin) begin
            r_status <= sab_pkg::STAT_OK;
            if (term > sab_pkg::OUT_MAX) begin
                r_res <= sab_pkg::AHEAD_W'(sab_pkg::OUT_MAX);
            end else if (term < sab_pkg::OUT_MIN) begin
                r_res <= sab_pkg::AHEAD_W'(sab_pkg::OUT_MIN);
            end else begin
                r_res <= term[sab_pkg::AHEAD_W-1:0];
            end
        end
    end

    // Output register, freed as soon as its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_ahead  <= r_res;
            r_out_status <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {5'b0, r_out_status, r_out_ahead};

    // Status toward the controller; the kind is taken from the offered transfer.
    always_comb begin
        o_flags.mode        = i_in_user;
        o_flags.cur_neg     = r_cur[sab_pkg::CUR_W-1];
        o_flags.n_zero      = (n_seg == '0);
        o_flags.elapsed_pos = !elapsed[sab_pkg::TIME_W] && (elapsed != '0);
        o_flags.spd_zero    = (r_spd == '0);
        o_flags.len_zero    = (r_len == '0);
        o_flags.idx_lt_cur  = (r_idx < cur_u);
        o_flags.is_last     = (r_idx == last);
        o_flags.cur_ge_n    = (cur_u >= n_seg);
        o_flags.vcur_zero   = (r_vcur == '0);
        o_flags.div_done    = div_done;
        o_flags.out_free    = !r_out_valid || i_out_ready;
    end

endmodule

[src/sab_ctrl.sv]
// Controller state machine sequencing loads, the segment walk and the final sum.
module sab_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  sab_pkg::t_flags  i_flags,
    output sab_pkg::t_cmd    o_cmd
);

    sab_pkg::t_state r_state;
    sab_pkg::t_state n_state;
    logic            r_final;
    logic            n_final;
    logic            accept;

    assign o_in_ready = (r_state == sab_pkg::ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sab_pkg::ST_IDLE;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_final <= n_final;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_final = r_final;
        case (r_state)
            sab_pkg::ST_IDLE: begin
                if (accept) begin
                    n_final = 1'b0;
                    n_state = (i_flags.mode == sab_pkg::MODE_QUERY) ? sab_pkg::ST_CHECK
                                                                   : sab_pkg::ST_LOAD;
                end
            end
            sab_pkg::ST_LOAD:  n_state = sab_pkg::ST_DONE;
            sab_pkg::ST_CHECK: begin
                if (i_flags.cur_neg || i_flags.n_zero || !i_flags.elapsed_pos) begin
                    n_state = sab_pkg::ST_DONE;
                end else begin
                    n_state = sab_pkg::ST_READ;
                end
            end
            sab_pkg::ST_READ:  n_state = sab_pkg::ST_LATCH;
            sab_pkg::ST_LATCH: n_state = sab_pkg::ST_EVAL;
            sab_pkg::ST_EVAL: begin
                if (i_flags.spd_zero) begin
                    n_state = i_flags.len_zero ? sab_pkg::ST_NEXT : sab_pkg::ST_DONE;
                end else if (i_flags.idx_lt_cur) begin
                    n_state = sab_pkg::ST_MUL_LO;
                end else begin
                    n_state = sab_pkg::ST_NEXT;
                end
            end
            sab_pkg::ST_NEXT: begin
                n_state = i_flags.is_last ? sab_pkg::ST_POST : sab_pkg::ST_READ;
            end
            sab_pkg::ST_MUL_LO:  n_state = sab_pkg::ST_MUL_HI;
            sab_pkg::ST_MUL_HI:  n_state = sab_pkg::ST_DIV_GO;
            sab_pkg::ST_DIV_GO:  n_state = sab_pkg::ST_DIV_WAIT;
            sab_pkg::ST_DIV_WAIT: begin
                if (i_flags.div_done) begin
                    n_state = r_final ? sab_pkg::ST_FIN : sab_pkg::ST_ACC;
                end
            end
            sab_pkg::ST_ACC: n_state = sab_pkg::ST_NEXT;
            sab_pkg::ST_POST: begin
                if (i_flags.cur_ge_n || i_flags.vcur_zero) begin
                    n_state = sab_pkg::ST_DONE;
                end else begin
                    n_final = 1'b1;
                    n_state = sab_pkg::ST_MUL_LO;
                end
            end
            sab_pkg::ST_FIN:  n_state = sab_pkg::ST_DONE;
            sab_pkg::ST_DONE: begin
                if (i_flags.out_free) begin
                    n_state = sab_pkg::ST_IDLE;
                end
            end
            default: n_state = sab_pkg::ST_IDLE;
        endcase
    end

    // Commands for the datapath.
    always_comb begin
        o_cmd           = '0;
        o_cmd.status    = sab_pkg::STAT_OK;
        o_cmd.final_sel = r_final;
        case (r_state)
            sab_pkg::ST_IDLE: o_cmd.capture = accept;
            sab_pkg::ST_LOAD: begin
                o_cmd.load_wr    = 1'b1;
                o_cmd.set_status = 1'b1;
            end
            sab_pkg::ST_CHECK: begin
                if (i_flags.cur_neg || i_flags.n_zero) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = sab_pkg::STAT_NO_SEG;
                end else if (!i_flags.elapsed_pos) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = sab_pkg::STAT_NO_ELAPSE;
                end
            end
            sab_pkg::ST_READ:  o_cmd.rd = 1'b1;
            sab_pkg::ST_LATCH: o_cmd.latch = 1'b1;
            sab_pkg::ST_EVAL: begin
                if (i_flags.spd_zero && !i_flags.len_zero) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = sab_pkg::STAT_HOLE;
                end
            end
            sab_pkg::ST_NEXT:   o_cmd.idx_inc = !i_flags.is_last;
            sab_pkg::ST_MUL_LO: o_cmd.mul_lo = 1'b1;
            sab_pkg::ST_MUL_HI: o_cmd.mul_hi = 1'b1;
            sab_pkg::ST_DIV_GO: o_cmd.div_go = 1'b1;
            sab_pkg::ST_DIV_WAIT: begin
            end
            sab_pkg::ST_ACC: o_cmd.acc = 1'b1;
            sab_pkg::ST_POST: begin
                o_cmd.post = 1'b1;
                if (i_flags.cur_ge_n) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = sab_pkg::STAT_BEYOND;
                end else if (i_flags.vcur_zero) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = sab_pkg::STAT_NO_SPEED;
                end
            end
            sab_pkg::ST_FIN:  o_cmd.fin = 1'b1;
            sab_pkg::ST_DONE: o_cmd.out_load = i_flags.out_free;
            default: begin
            end
        endcase
    end

endmodule

[src/stage_schedule_ahead_behind.sv]
// Top level of the rally stage schedule ahead/behind tracker.
// A load item (tuser 0) writes one segment entry; its result goes to the output
// register through the load and done states, after which the next item can follow.
// A query item (tuser 1) walks the segment table one entry at a time; each
// completed segment with a target speed passes through the 64-step bit-serial
// divider, a skipped or current segment does not, and the final ahead/behind
// figure takes one more pass through the divider.
// One item is worked at a time; the next is taken while a result still waits
// in the output register. The result gives ms ahead (positive) or behind.
module stage_schedule_ahead_behind #(
    parameter int MAX_SEGMENTS = sab_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // entry_index[5:0], entry_length[37:6], entry_speed[77:38],
    // current_segment[84:78], now_ms[124:85], driven_counts[164:125]
    input  logic [sab_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // mode[0]
    input  logic                            s_axis_tuser,
    // Result stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // ahead_ms[47:0], status[50:48]
    output logic [sab_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [3:0]                      paddr,
    input  logic [63:0]                     pwdata,
    output logic [63:0]                     prdata,
    output logic                            pready
);

    logic [sab_pkg::TIME_W-1:0] r_stage_start;
    logic [sab_pkg::SIU_W-1:0]  r_siu;
    sab_pkg::t_cmd              cmd;
    sab_pkg::t_flags            flags;

    // Configuration registers: stage start at 0, segments in use at 8.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_start <= '0;
            r_siu         <= '0;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[3]) begin
                r_siu <= pwdata[sab_pkg::SIU_W-1:0];
            end else begin
                r_stage_start <= pwdata[sab_pkg::TIME_W-1:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[3] ? {57'b0, r_siu} : {24'b0, r_stage_start};

    sab_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_flags    (flags),
        .o_cmd      (cmd)
    );

    sab_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_flags       (flags),
        .i_in_data     (s_axis_tdata),
        .i_in_user     (s_axis_tuser),
        .i_stage_start (r_stage_start),
        .i_siu         (r_siu),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_data    (m_axis_tdata)
    );

endmodule

[sim/tb.sv]
// Testbench for the stage schedule ahead/behind tracker with a built-in predictor.
`timescale 1ns / 1ps

module tb;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    // entry_index, entry_length, entry_speed, current_segment, now_ms, driven_counts
    logic [sab_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    // mode
    logic                           s_axis_tuser = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // ahead_ms, status
    logic [sab_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [3:0]                     paddr = '0;
    logic [63:0]                    pwdata = '0;
    logic [63:0]                    prdata;
    logic                           pready;

    stage_schedule_ahead_behind uut (.*);

    localparam int STALL_LIMIT = 200000;

    // Register indexes.
    localparam int REG_START = 0;
    localparam int REG_SEGS  = 1;

    // Status in the upper bits, ahead_ms in the lower bits, as on the bus.
    typedef struct packed {
        sab_pkg::t_status            status;
        logic [sab_pkg::AHEAD_W-1:0] ahead;
    } t_result;

    // Predictor state.
    logic [sab_pkg::LEN_W-1:0]  tbl_len [64];
    logic [sab_pkg::SPD_W-1:0]  tbl_spd [64];
    logic [sab_pkg::TIME_W-1:0] cfg_start;
    logic [sab_pkg::SIU_W-1:0]  cfg_segs;

    t_result  pending_results[$];
    int       fail_count = 0;
    int       idle_cycles = 0;
    int       burst_left = 0;

    always #6 i_clk = ~i_clk;

    // Scaled time |m| * 3600000 / v, rounded, clamped at 2^61.
    function automatic logic [63:0] scaled_time(logic [63:0] m, logic [63:0] v);
        logic [63:0] q, r, w;
        q = m / v;
        r = m % v;
        if (q > sab_pkg::CLAMP61 / 64'd3600000) return sab_pkg::CLAMP61;
        w = q * 64'd3600000 + (r * 64'd3600000 + v / 2) / v;
        return (w > sab_pkg::CLAMP61) ? sab_pkg::CLAMP61 : w;
    endfunction

    // Predict the result of a query against the current table and registers.
    function automatic t_result predict_ahead(logic signed [6:0] cur,
                                              logic [39:0] now, logic signed [39:0] act);
        t_result res;
        longint n, elapsed, last, d, term;
        logic [63:0] len_c, t_c, mag;
        bit hole;
        res.ahead = '0;
        n = (cfg_segs > 64) ? 64 : cfg_segs;
        len_c = 0;
        t_c = 0;
        hole = 0;
        if (cur < 0 || n == 0) begin
            res.status = sab_pkg::STAT_NO_SEG;
            return res;
        end
        elapsed = longint'({24'd0, now}) - longint'({24'd0, cfg_start});
        if (elapsed <= 0) begin
            res.status = sab_pkg::STAT_NO_ELAPSE;
            return res;
        end
        last = (cur < n) ? cur : n - 1;
        for (int i = 0; i <= last; i++) begin
            if (tbl_spd[i] == 0) begin
                if (tbl_len[i] > 0) hole = 1;
            end else if (i < cur) begin
                len_c += tbl_len[i];
                t_c += ({32'd0, tbl_len[i]} * 64'd3600000 + tbl_spd[i] / 2) / tbl_spd[i];
                if (t_c > sab_pkg::CLAMP61) t_c = sab_pkg::CLAMP61;
            end
        end
        if (hole) res.status = sab_pkg::STAT_HOLE;
        else if (cur >= n) res.status = sab_pkg::STAT_BEYOND;
        else if (tbl_spd[cur] == 0) res.status = sab_pkg::STAT_NO_SPEED;
        else begin
            res.status = sab_pkg::STAT_OK;
            d = longint'(act) - longint'(len_c);
            mag = scaled_time(d < 0 ? -d : d, {24'd0, tbl_spd[cur]});
            term = (d < 0 ? -longint'(mag) : longint'(mag)) - elapsed + longint'(t_c);
            if (term > sab_pkg::OUT_MAX) term = sab_pkg::OUT_MAX;
            if (term < sab_pkg::OUT_MIN) term = sab_pkg::OUT_MIN;
            res.ahead = term[47:0];
        end
        return res;
    endfunction

    // Write one register over the configuration port.
    task automatic write_reg(int idx, logic [63:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 4'(idx * 8);
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_START) cfg_start = value[39:0];
        else cfg_segs = value[6:0];
    endtask

    // Send one item, with bursts and random gaps, and record its expected result.
    task automatic send_item(sab_pkg::t_mode mode, logic [5:0] idx, logic [31:0] len,
                             logic [39:0] spd, logic signed [6:0] cur,
                             logic [39:0] now, logic [39:0] act);
        t_result res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            if ($urandom_range(0, 1)) repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        burst_left--;
        if (mode == sab_pkg::MODE_LOAD) begin
            tbl_len[idx] = len;
            tbl_spd[idx] = spd;
            res.ahead = '0;
            res.status = sab_pkg::STAT_OK;
        end else begin
            res = predict_ahead(cur, now, act);
        end
        pending_results.insert(pending_results.size(), res);
        @(negedge i_clk);
        s_axis_tdata <= {3'd0, act, now, cur, spd, len, idx};
        s_axis_tuser <= mode;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic load_seg(int idx, logic [31:0] len, logic [39:0] spd);
        send_item(sab_pkg::MODE_LOAD, 6'(idx), len, spd, '0, '0, '0);
    endtask

    task automatic query(logic signed [6:0] cur, logic [39:0] now, logic [39:0] act);
        send_item(sab_pkg::MODE_QUERY, 6'($urandom), $urandom, 40'({$urandom, $urandom}),
                  cur, now, act);
    endtask

    // Wait until every expected result has come.
    task automatic drain;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // Extremes and each status case.
    task automatic test_directed;
        write_reg(REG_START, 64'd1000);
        write_reg(REG_SEGS, 64'd0);
        load_seg(0, 32'd1000, 40'd3600000);
        load_seg(1, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
        load_seg(2, 32'd0, 40'd0);
        load_seg(3, 32'd500, 40'd1);
        load_seg(4, 32'd7, 40'd0);
        load_seg(63, 32'd0, 40'd0);
        query(7'sd0, 40'd5000, 40'd10);
        drain();
        write_reg(REG_SEGS, 64'd3);
        query(-7'sd1, 40'd5000, 40'd10);
        query(7'sd0, 40'd1000, 40'd10);
        query(7'sd0, 40'd0, 40'd10);
        query(7'sd0, 40'hFF_FFFF_FFFF, 40'h80_0000_0000);
        query(7'sd0, 40'd2000, 40'h7F_FFFF_FFFF);
        query(7'sd1, 40'd5000, 40'hFF_FFFF_FFFF);
        query(7'sd2, 40'd5000, 40'd100);
        query(7'sd3, 40'd5000, 40'd100);
        query(7'sd63, 40'd5000, 40'd100);
        drain();
        write_reg(REG_SEGS, 64'd5);
        query(7'sd3, 40'd5000, 40'd100);
        query(7'sd4, 40'd5000, 40'd100);
        drain();
        write_reg(REG_START, 64'hFF_FFFF_FFFF);
        query(7'sd0, 40'hFF_FFFF_FFFF, 40'd1);
        drain();
        write_reg(REG_START, 64'd0);
        write_reg(REG_SEGS, 64'd4);
        query(7'sd3, 40'd1, 40'h80_0000_0000);
        query(7'sd3, 40'hFF_FFFF_FFFF, 40'h7F_FFFF_FFFF);
        drain();
    endtask

    // Random stages: fill a table, mostly a short one, then mostly well-formed queries.
    task automatic test_random;
        int segs;
        logic [39:0] spd;
        for (int phase = 0; phase < 6; phase++) begin
            segs = (phase == 5) ? 64 : $urandom_range(1, 8);
            for (int i = 0; i < segs; i++) begin
                spd = ($urandom_range(0, 9) == 0) ? 40'd0 :
                      ($urandom_range(0, 3) == 0) ? 40'({$urandom, $urandom}) :
                      40'($urandom_range(1, 200000));
                load_seg(i, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5000),
                         spd);
            end
            drain();
            write_reg(REG_START, ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} :
                                 64'($urandom_range(0, 100000)));
            write_reg(REG_SEGS, (phase == 4) ? 64'd64 : 64'($urandom_range(1, segs + 1)));
            if (cfg_segs > segs) write_reg(REG_SEGS, 64'(segs));
            for (int k = 0; k < 6; k++) begin
                query(($urandom_range(0, 7) == 0) ? 7'($urandom) :
                      7'($urandom_range(0, cfg_segs)),
                      ($urandom_range(0, 3) == 0) ? 40'({$urandom, $urandom}) :
                      40'(cfg_start + $urandom_range(0, 2000000)),
                      ($urandom_range(0, 3) == 0) ? 40'({$urandom, $urandom}) :
                      40'($urandom_range(0, 40000)));
            end
            drain();
        end
    endtask

    // Receiver stall pattern.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 255) < 64) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[50:0];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.ahead !== want.ahead)
                    $display("%0t: ahead_ms expected %0d actual %0d", $time,
                             $signed(want.ahead), $signed(got.ahead));
                if (got.status !== want.status)
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, got.status);
                if (got !== want) fail_count++;
            end
        end
    end

    // Watchdog on cycles with no transfer.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        cfg_start = '0;
        cfg_segs = '0;
        for (int i = 0; i < 64; i++) begin
            tbl_len[i] = '0;
            tbl_spd[i] = '0;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random();
        drain();
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
